### rtl/core/exact_rne_recip_rsqrt_mantissa_defines.svh
// Assertion macros shared by the RTL of the reciprocal / rsqrt mantissa unit.
// Define ASSERT_OFF to compile the checks away.
`ifndef EXACT_RNE_RECIP_RSQRT_MANTISSA_DEFINES_SVH
`define EXACT_RNE_RECIP_RSQRT_MANTISSA_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

### rtl/core/rrsq_pkg.sv
package rrsq_pkg;

    localparam logic [1:0] FUNC_RECIP      = 2'd0;
    localparam logic [1:0] FUNC_RSQRT_EVEN = 2'd1;
    localparam logic [1:0] FUNC_RSQRT_ODD  = 2'd2;

    typedef struct packed {
        logic valid;
        logic is_sqrt;
    } t_ctl;

endpackage

### rtl/core/exact_rne_recip_rsqrt_mantissa.sv
// Correctly rounded reciprocal / reciprocal square root significand unit.
// A transaction is taken every cycle that start is high; busy is always low.
// Each result appears on o_result for one cycle, flagged by o_valid, after
// its transaction has passed the row of FRAC_BITS+2 digit cells, one quotient
// or root bit per cell, and then one rounding stage; results leave in the
// order the operands entered. The receiver cannot stall the unit, so it
// must take each result in the cycle it is shown.
`include "exact_rne_recip_rsqrt_mantissa_defines.svh"

module exact_rne_recip_rsqrt_mantissa
    import rrsq_pkg::*;
#(
    parameter int FRAC_BITS = 23
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_func,
    input  logic [FRAC_BITS-1:0]   i_fraction,
    output logic                   o_valid,
    output logic [FRAC_BITS+1:0]   o_result
);

    localparam int MW    = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 2;
    localparam int WW    = 2 * FRAC_BITS + 6;
    localparam int NCELL = FRAC_BITS + 2;
    localparam int LAT   = NCELL + 1;

    localparam logic [WW-1:0] X0_EVEN = {{(WW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [WW-1:0] X0_ODD  = {{(WW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [QW-1:0] RES_MIN = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [QW-1:0] RES_MAX = {{(QW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);

    t_ctl          s_ctl [0:NCELL];
    logic [MW-1:0] s_m   [0:NCELL];
    logic [WW-1:0] s_x   [0:NCELL];
    logic [WW-1:0] s_d   [0:NCELL];
    logic [QW-1:0] s_q   [0:NCELL];

    assign busy = 1'b0;

    // Head of the row: the first partial remainder is the numerator scaled to
    // the top digit, and the subtrahend starts as the mantissa itself.
    assign s_ctl[0].valid   = start && !busy;
    assign s_ctl[0].is_sqrt = (i_func != FUNC_RECIP);
    assign s_m[0]           = {1'b1, i_fraction};
    assign s_x[0]           = (i_func == FUNC_RSQRT_ODD) ? X0_ODD : X0_EVEN;
    assign s_d[0]           = {{(WW-MW){1'b0}}, 1'b1, i_fraction};
    assign s_q[0]           = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        rrsq_cell #(
            .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_m     (s_m[g]),
            .i_x     (s_x[g]),
            .i_d     (s_d[g]),
            .i_q     (s_q[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_m     (s_m[g+1]),
            .o_x     (s_x[g+1]),
            .o_d     (s_d[g+1]),
            .o_q     (s_q[g+1])
        );
    end

    rrsq_round #(
        .FRAC_BITS(FRAC_BITS)
    ) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl[NCELL]),
        .i_x      (s_x[NCELL]),
        .i_d      (s_d[NCELL]),
        .i_q      (s_q[NCELL]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `ASSERT_IMPLY(a_strobe_latency, i_clk, i_rst_n, o_valid, $past(start, LAT))
    `ASSERT_ALWAYS(a_result_range, i_clk, i_rst_n, !o_valid || (o_result >= RES_MIN && o_result <= RES_MAX))
    `ASSERT_IMPLY(a_recip_of_one, i_clk, i_rst_n, o_valid && $past(i_func, LAT) == FUNC_RECIP && $past(i_fraction, LAT) == '0, o_result == RES_MAX)

endmodule

### rtl/core/rrsq_cell.sv
`include "exact_rne_recip_rsqrt_mantissa_defines.svh"

module rrsq_cell
    import rrsq_pkg::*;
#(
    parameter int FRAC_BITS = 23
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [FRAC_BITS:0]        i_m,
    input  logic [2*FRAC_BITS+5:0]    i_x,
    input  logic [2*FRAC_BITS+5:0]    i_d,
    input  logic [FRAC_BITS+1:0]      i_q,
    output t_ctl                      o_ctl,
    output logic [FRAC_BITS:0]        o_m,
    output logic [2*FRAC_BITS+5:0]    o_x,
    output logic [2*FRAC_BITS+5:0]    o_d,
    output logic [FRAC_BITS+1:0]      o_q
);

    localparam int MW = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int WW = 2 * FRAC_BITS + 6;

    logic [WW:0]   w_diff;
    logic          w_bit;
    logic [WW-1:0] w_rem;
    logic [WW-1:0] w_m_ext;
    logic [MW+1:0] w_m3;
    logic [WW-1:0] w_d2;
    logic [WW-1:0] w_dp;
    logic [WW-1:0] w_dm;

    t_ctl          r_ctl;
    logic [MW-1:0] r_m;
    logic [WW-1:0] r_x;
    logic [WW-1:0] r_d;
    logic [QW-1:0] r_q;
    logic [WW-1:0] n_x;
    logic [WW-1:0] n_d;
    logic [QW-1:0] n_q;
    logic [WW-1:0] w_rm_ext;

    // Trial subtraction of the current subtrahend; a non-negative result sets the digit.
    assign w_diff  = {1'b0, i_x} - {1'b0, i_d};
    assign w_bit   = ~w_diff[WW];
    assign w_rem   = w_bit ? w_diff[WW-1:0] : i_x;

    assign w_m_ext = {{(WW-MW){1'b0}}, i_m};
    assign w_m3    = {2'b00, i_m} + {1'b0, i_m, 1'b0};
    assign w_d2    = {i_d[WW-2:0], 1'b0};

    // For the root the subtrahend is 4*q*m/2^(b+1) + m, scaled to the next digit.
    assign w_dp    = w_d2 + {{(WW-MW-2){1'b0}}, w_m3};
    assign w_dm    = w_d2 - w_m_ext;

    always_comb begin
        if (i_ctl.is_sqrt) begin
            n_x = {w_rem[WW-3:0], 2'b00};
            n_d = w_bit ? w_dp : w_dm;
        end else begin
            n_x = {w_rem[WW-2:0], 1'b0};
            n_d = i_d;
        end
        n_q = {i_q[QW-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= i_m;
        r_x <= n_x;
        r_d <= n_d;
        r_q <= n_q;
    end

    assign o_ctl = r_ctl;
    assign o_m   = r_m;
    assign o_x   = r_x;
    assign o_d   = r_d;
    assign o_q   = r_q;

    assign w_rm_ext = {{(WW-MW){1'b0}}, r_m};

    `ASSERT_IMPLY(a_recip_divisor_held, i_clk, i_rst_n, r_ctl.valid && !r_ctl.is_sqrt, r_d == w_rm_ext)
    `ASSERT_IMPLY(a_recip_rem_bound, i_clk, i_rst_n, r_ctl.valid && !r_ctl.is_sqrt, r_x < (w_rm_ext << 1))
    `ASSERT_IMPLY(a_sqrt_sub_mod4, i_clk, i_rst_n, r_ctl.valid && r_ctl.is_sqrt, r_d[1:0] == r_m[1:0])

endmodule

### rtl/core/rrsq_round.sv
module rrsq_round
    import rrsq_pkg::*;
#(
    parameter int FRAC_BITS = 23
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [2*FRAC_BITS+5:0]    i_x,
    input  logic [2*FRAC_BITS+5:0]    i_d,
    input  logic [FRAC_BITS+1:0]      i_q,
    output logic                      o_valid,
    output logic [FRAC_BITS+1:0]      o_result
);

    localparam int QW = FRAC_BITS + 2;

    logic          w_up;
    logic          r_valid;
    logic [QW-1:0] r_result;
    logic [QW-1:0] n_result;

    // The scaled remainder against the half-step term decides rounding; a tie
    // goes to the even quotient.
    assign w_up     = (i_x > i_d) || ((i_x == i_d) && i_q[0]);
    assign n_result = i_q + {{(QW-1){1'b0}}, w_up};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
